// File: rtl/core/binary_to_decimal_ascii_top_assert.svh
// Assertion macros shared by the conversion core.
// The clock is clk and the reset is rst_n in every module that uses them.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

`ifndef SYNTH

// Checks a property on every rising clock edge outside reset.
`define B2DA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("binary_to_decimal_ascii assertion failed");

// Checks that a condition in one cycle is followed by another in the next.
`define B2DA_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("binary_to_decimal_ascii sequence check failed");

`else

`define B2DA_ASSERT(label, prop)
`define B2DA_ASSERT_NEXT(label, cond, conseq)

`endif

`endif

// File: rtl/core/b2da_pkg.sv
package b2da_pkg;

    // Width of the value port.
    localparam int IN_BITS = 32;
    // Default width of the number being converted.
    localparam int VALUE_BITS_DEF = 32;
    // Width of one BCD digit and of one output character.
    localparam int DIGIT_W = 4;
    localparam int CHAR_W = 6;
    // ASCII code of the character '0', cut to the character width.
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    // A digit at or above this value is corrected before it doubles.
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    // Control handed from the sequencer to every digit cell.
    typedef struct packed {
        logic clear;
        logic bit_shift;
        logic digit_shift;
    } cell_ctl_t;

endpackage

// File: rtl/core/b2da_cell.sv
// One BCD digit of the shift-and-add-3 converter.
module b2da_cell
    import b2da_pkg::*;
(
    input  logic               clk,
    input  cell_ctl_t          ctl,
    input  logic               bit_in,
    input  logic [DIGIT_W-1:0] digit_in,
    output logic               bit_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // Add three to a digit of five or more so that doubling carries in decimal.
    assign adj = (digit_reg >= ADJ_LIMIT) ? digit_reg + ADJ_ADD : digit_reg;
    assign bit_out = adj[DIGIT_W-1];
    assign digit = digit_reg;

    // Clear, take one binary bit from below, or take the digit from below.
    always_comb
    begin
        digit_next = digit_reg;
        if (ctl.clear)
        begin
            digit_next = '0;
        end
        else if (ctl.bit_shift)
        begin
            digit_next = {adj[DIGIT_W-2:0], bit_in};
        end
        else if (ctl.digit_shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// File: rtl/core/binary_to_decimal_ascii_top.sv
// Converts one unsigned number to ASCII decimal digits, most significant first.
// Busy is high while a number is converted and while its digits are emitted; start is
// taken only while idle, so a new item is not taken before the last digit beat of the last one.
// Results cannot be stalled; each beat is shown for one cycle with valid high.
// Reset (rst_n, asynchronous) returns the sequencer to idle and drops valid.
`include "binary_to_decimal_ascii_top_assert.svh"

module binary_to_decimal_ascii_top
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [IN_BITS-1:0] value,
    output logic              valid,
    output logic [CHAR_W-1:0] digit_char,
    output logic              last
);

    // Only the low bits of the port can ever be set.
    localparam int EFF_BITS = (VALUE_BITS > IN_BITS) ? IN_BITS : VALUE_BITS;
    // Decimal digits of 2**EFF_BITS - 1 (1233/4096 approximates log10 of 2).
    localparam int DIGITS = ((EFF_BITS * 1233) >> 12) + 1;
    localparam int CNT_W = $clog2(EFF_BITS);
    localparam int REM_W = $clog2(DIGITS + 1);
    // ASCII code of the character '9'.
    localparam logic [CHAR_W-1:0] CHAR_MAX = ASCII_ZERO + CHAR_W'(DIGIT_MAX);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   rem_next;
    logic               seen_reg;
    logic               seen_next;
    logic [EFF_BITS-1:0] shreg_reg;
    logic [EFF_BITS-1:0] shreg_next;
    logic               valid_reg;
    logic               valid_next;
    logic [CHAR_W-1:0]  digit_char_reg;
    logic [CHAR_W-1:0]  digit_char_next;
    logic               last_reg;
    logic               last_next;
    cell_ctl_t          ctl;
    logic [DIGITS-1:0]  carry;
    logic [DIGIT_W-1:0] digits [DIGITS];
    logic [DIGIT_W-1:0] top_digit;
    logic               fire;
    logic               last_slot;

    assign top_digit = digits[DIGITS-1];
    assign busy = (state_reg != ST_IDLE);
    assign valid = valid_reg;
    assign digit_char = digit_char_reg;
    assign last = last_reg;

    // Row of digit cells: bits enter at cell 0, digits leave from the top cell.
    for (genvar i = 0; i < DIGITS; i++)
    begin : g_cell
        logic               bit_in;
        logic [DIGIT_W-1:0] digit_in;

        if (i == 0)
        begin : g_first
            assign bit_in = shreg_reg[EFF_BITS-1];
            assign digit_in = '0;
        end
        else
        begin : g_rest
            assign bit_in = carry[i-1];
            assign digit_in = digits[i-1];
        end

        b2da_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .bit_in   (bit_in),
            .digit_in (digit_in),
            .bit_out  (carry[i]),
            .digit    (digits[i])
        );
    end

    // The lowest digit is the one left when a single slot remains.
    assign last_slot = (rem_reg == REM_W'(1));

    // A digit is shown once a nonzero one has been seen, and always the last.
    assign fire = seen_reg || (top_digit != '0) || last_slot;

    // Sequencer next state and cell control.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        seen_next = seen_reg;
        shreg_next = shreg_reg;
        valid_next = 1'b0;
        digit_char_next = digit_char_reg;
        last_next = last_reg;
        ctl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.clear = 1'b1;
                    shreg_next = value[EFF_BITS-1:0];
                    cnt_next = CNT_W'(EFF_BITS - 1);
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                ctl.bit_shift = 1'b1;
                shreg_next = {shreg_reg[EFF_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    rem_next = REM_W'(DIGITS);
                    seen_next = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                ctl.digit_shift = 1'b1;
                valid_next = fire;
                digit_char_next = ASCII_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, top_digit};
                last_next = last_slot;
                seen_next = fire;
                rem_next = rem_reg - REM_W'(1);
                if (last_slot)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Working and output beat registers.
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        seen_reg <= seen_next;
        shreg_reg <= shreg_next;
        digit_char_reg <= digit_char_next;
        last_reg <= last_next;
    end

    `B2DA_ASSERT(a_char_range, !valid || ((digit_char >= ASCII_ZERO) && (digit_char <= CHAR_MAX)))
    `B2DA_ASSERT(a_no_top_overflow, (state_reg != ST_CONVERT) || !carry[DIGITS-1])
    `B2DA_ASSERT(a_top_is_digit, (state_reg != ST_EMIT) || (top_digit <= DIGIT_MAX))
    `B2DA_ASSERT_NEXT(a_last_beat, (state_reg == ST_EMIT) && last_slot, valid && last && !busy)
    `B2DA_ASSERT_NEXT(a_no_beat_after_last, valid && last, !valid)

endmodule
